@@ hdl/flrw_pkg.sv @@
// shared types and constants of the reader-writer lock manager
`timescale 1ns / 1ps
package flrw_pkg;

  // default sizes and fixed field widths
  localparam int QUEUE_DEPTH_DEF    = 16;
  localparam int REQUESTER_BITS_DEF = 8;
  localparam int ID_FIELD_W         = 8;
  localparam int READER_W           = 9;
  localparam int READER_MAX         = 511;
  localparam int CMD_DEPTH          = 2;

  // action codes of an input item
  localparam logic [1:0] ACT_READ   = 2'd0;
  localparam logic [1:0] ACT_WRITE  = 2'd1;
  localparam logic [1:0] ACT_UNLOCK = 2'd2;

  // decoded command kind
  typedef enum logic [1:0] {
    OP_READ,
    OP_WRITE,
    OP_UNLOCK,
    OP_BAD
  } op_e;

  // result event codes
  typedef enum logic [2:0] {
    EV_GRANTED  = 3'd0,
    EV_QUEUED   = 3'd1,
    EV_WOKEN    = 3'd2,
    EV_RELEASED = 3'd3,
    EV_ERROR    = 3'd4
  } ev_e;

  // lock mode
  typedef enum logic [1:0] {
    MODE_FREE  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } mode_e;

  // back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WAKE,
    ST_WAKE_R
  } bk_state_e;

  // input item
  typedef struct packed {
    logic [1:0]            action;
    logic [ID_FIELD_W-1:0] requester;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [ID_FIELD_W-1:0] who;
    logic [2:0]            event_res;
    logic [1:0]            mode_after;
    logic                  is_last;
  } out_item_t;

  // command passed from front to back
  typedef struct packed {
    op_e                   op;
    logic [ID_FIELD_W-1:0] id;
  } cmd_t;

endpackage

@@ hdl/flrw_front.sv @@
// front end: accepts request items and decodes them into commands
`timescale 1ns / 1ps
module flrw_front (
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  flrw_pkg::in_item_t  in_item_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output flrw_pkg::cmd_t      q_cmd_o
);

  // hold off the sender while the command queue is full
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // action decode
  always_comb begin
    q_cmd_o.id = in_item_i.requester;
    unique case (in_item_i.action)
      flrw_pkg::ACT_READ:   q_cmd_o.op = flrw_pkg::OP_READ;
      flrw_pkg::ACT_WRITE:  q_cmd_o.op = flrw_pkg::OP_WRITE;
      flrw_pkg::ACT_UNLOCK: q_cmd_o.op = flrw_pkg::OP_UNLOCK;
      default:              q_cmd_o.op = flrw_pkg::OP_BAD;
    endcase
  end

endmodule

@@ hdl/flrw_cmd_queue.sv @@
// short command queue between the front end and the back end
`timescale 1ns / 1ps
module flrw_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  flrw_pkg::cmd_t cmd_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output flrw_pkg::cmd_t cmd_o
);

  localparam int Depth = flrw_pkg::CMD_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  flrw_pkg::cmd_t  buf_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = buf_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ hdl/flrw_back.sv @@
// back end: lock state, wait queue memory and result sequencing
`timescale 1ns / 1ps
module flrw_back #(
  parameter int QUEUE_DEPTH    = flrw_pkg::QUEUE_DEPTH_DEF,
  parameter int REQUESTER_BITS = flrw_pkg::REQUESTER_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  flrw_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output flrw_pkg::out_item_t out_item_o
);

  localparam int IdFieldW = flrw_pkg::ID_FIELD_W;
  localparam int IdW      = (REQUESTER_BITS < IdFieldW) ? REQUESTER_BITS : IdFieldW;
  localparam int EntW     = IdW + 1;
  localparam int PtrW     = $clog2(QUEUE_DEPTH);
  localparam int CntW     = $clog2(QUEUE_DEPTH + 1);
  localparam int HoldW    = (CntW > flrw_pkg::READER_W) ? CntW : flrw_pkg::READER_W;

  // sequencer and lock state
  flrw_pkg::bk_state_e state_q, state_d;
  flrw_pkg::cmd_t      cmd_q, cmd_d;
  flrw_pkg::mode_e     mode_q, mode_d;
  logic [IdW-1:0]      owner_q, owner_d;
  logic [HoldW-1:0]    holders_q, holders_d;
  logic [IdW-1:0]      cur_q, cur_d;
  logic [PtrW-1:0]     head_q, head_d;
  logic [PtrW-1:0]     tail_q, tail_d;
  logic [CntW-1:0]     count_q, count_d;

  // wait queue memory, registered read at the next head
  logic [EntW-1:0]     wait_mem_q [QUEUE_DEPTH];
  logic [EntW-1:0]     rd_q;

  // output register
  logic                out_valid_q;
  flrw_pkg::out_item_t out_q;

  // command step decisions
  flrw_pkg::ev_e       ex_ev;
  flrw_pkg::mode_e     ex_mode;
  logic                ex_push;
  logic                ex_wake;
  logic [HoldW-1:0]    ex_holders;
  logic [IdW-1:0]      ex_owner;

  logic                emit_ok;
  logic                emit;
  flrw_pkg::out_item_t emit_item;
  logic                do_pop;
  logic                q_empty;
  logic                q_full;
  logic                head_wr;
  logic [IdW-1:0]      head_id;
  logic [IdW-1:0]      req_id;
  logic                run_last;
  logic [HoldW-1:0]    rd_dec;

  assign emit_ok  = !out_valid_q || !out_stall_i;
  assign q_empty  = (count_q == '0);
  assign q_full   = (count_q >= CntW'(QUEUE_DEPTH - 1));
  assign head_wr  = rd_q[IdW];
  assign head_id  = rd_q[IdW-1:0];
  assign req_id   = cmd_q.id[IdW-1:0];
  assign run_last = q_empty || head_wr;
  assign rd_dec   = (holders_q != '0) ? holders_q - 1'b1 : holders_q;

  // classify the current command against the lock state
  always_comb begin
    ex_ev      = flrw_pkg::EV_ERROR;
    ex_mode    = mode_q;
    ex_push    = 1'b0;
    ex_wake    = 1'b0;
    ex_holders = holders_q;
    ex_owner   = owner_q;
    unique case (cmd_q.op)
      flrw_pkg::OP_READ: begin
        if (mode_q != flrw_pkg::MODE_WRITE && q_empty) begin
          if (holders_q < HoldW'(flrw_pkg::READER_MAX)) begin
            ex_ev      = flrw_pkg::EV_GRANTED;
            ex_holders = holders_q + 1'b1;
            ex_mode    = flrw_pkg::MODE_READ;
          end
        end else if (!q_full) begin
          ex_ev   = flrw_pkg::EV_QUEUED;
          ex_push = 1'b1;
        end
      end
      flrw_pkg::OP_WRITE: begin
        if (mode_q == flrw_pkg::MODE_WRITE && owner_q == req_id) begin
          ex_ev = flrw_pkg::EV_ERROR;
        end else if (mode_q == flrw_pkg::MODE_FREE && q_empty) begin
          ex_ev    = flrw_pkg::EV_GRANTED;
          ex_mode  = flrw_pkg::MODE_WRITE;
          ex_owner = req_id;
        end else if (!q_full) begin
          ex_ev   = flrw_pkg::EV_QUEUED;
          ex_push = 1'b1;
        end
      end
      flrw_pkg::OP_UNLOCK: begin
        if (mode_q == flrw_pkg::MODE_WRITE) begin
          if (owner_q == req_id) begin
            ex_ev   = flrw_pkg::EV_RELEASED;
            ex_wake = 1'b1;
          end
        end else if (mode_q == flrw_pkg::MODE_READ) begin
          ex_ev      = flrw_pkg::EV_RELEASED;
          ex_holders = rd_dec;
          ex_wake    = (rd_dec == '0);
        end
      end
      default: begin
        ex_ev = flrw_pkg::EV_ERROR;
      end
    endcase
    // handing the lock to the queue head fixes the final mode now
    if (ex_wake) begin
      ex_holders = '0;
      ex_owner   = '0;
      if (q_empty) begin
        ex_mode = flrw_pkg::MODE_FREE;
      end else if (head_wr) begin
        ex_mode = flrw_pkg::MODE_WRITE;
      end else begin
        ex_mode = flrw_pkg::MODE_READ;
      end
    end
  end

  // datapath and result outputs per state
  always_comb begin
    cmd_d     = cmd_q;
    mode_d    = mode_q;
    owner_d   = owner_q;
    holders_d = holders_q;
    cur_d     = cur_q;
    cmd_pop_o = 1'b0;
    emit      = 1'b0;
    emit_item = '0;
    do_pop    = 1'b0;
    unique case (state_q)
      flrw_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
        end
      end
      flrw_pkg::ST_EXEC: begin
        if (emit_ok) begin
          emit                 = 1'b1;
          emit_item.who        = IdFieldW'(req_id);
          emit_item.event_res  = ex_ev;
          emit_item.mode_after = ex_mode;
          emit_item.is_last    = !(ex_wake && !q_empty);
          mode_d               = ex_mode;
          owner_d              = ex_owner;
          holders_d            = ex_holders;
        end
      end
      flrw_pkg::ST_WAKE: begin
        if (head_wr) begin
          if (emit_ok) begin
            emit                 = 1'b1;
            emit_item.who        = IdFieldW'(head_id);
            emit_item.event_res  = flrw_pkg::EV_WOKEN;
            emit_item.mode_after = mode_q;
            emit_item.is_last    = 1'b1;
            owner_d              = head_id;
            do_pop               = 1'b1;
          end
        end else begin
          cur_d     = head_id;
          holders_d = HoldW'(1);
          do_pop    = 1'b1;
        end
      end
      flrw_pkg::ST_WAKE_R: begin
        if (emit_ok) begin
          emit                 = 1'b1;
          emit_item.who        = IdFieldW'(cur_q);
          emit_item.event_res  = flrw_pkg::EV_WOKEN;
          emit_item.mode_after = mode_q;
          emit_item.is_last    = run_last;
          if (!run_last) begin
            cur_d     = head_id;
            holders_d = holders_q + 1'b1;
            do_pop    = 1'b1;
          end
        end
      end
      default: begin
        cmd_pop_o = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      flrw_pkg::ST_IDLE: begin
        if (cmd_valid_i) state_d = flrw_pkg::ST_EXEC;
      end
      flrw_pkg::ST_EXEC: begin
        if (emit_ok) begin
          state_d = (ex_wake && !q_empty) ? flrw_pkg::ST_WAKE : flrw_pkg::ST_IDLE;
        end
      end
      flrw_pkg::ST_WAKE: begin
        if (!head_wr) begin
          state_d = flrw_pkg::ST_WAKE_R;
        end else if (emit_ok) begin
          state_d = flrw_pkg::ST_IDLE;
        end
      end
      flrw_pkg::ST_WAKE_R: begin
        if (emit_ok && run_last) state_d = flrw_pkg::ST_IDLE;
      end
      default: begin
        state_d = flrw_pkg::ST_IDLE;
      end
    endcase
  end

  // queue pointers, count never pushes and pops in one cycle
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (emit && state_q == flrw_pkg::ST_EXEC && ex_push) begin
      tail_d  = (tail_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end else if (do_pop) begin
      head_d  = (head_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= flrw_pkg::ST_IDLE;
      mode_q      <= flrw_pkg::MODE_FREE;
      owner_q     <= '0;
      holders_q   <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      owner_q   <= owner_d;
      holders_q <= holders_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    cur_q <= cur_d;
    if (emit) begin
      out_q <= emit_item;
    end
  end

  // wait queue memory: write at tail, read at next head
  always_ff @(posedge clk_i) begin
    if (emit && state_q == flrw_pkg::ST_EXEC && ex_push) begin
      wait_mem_q[tail_q] <= {cmd_q.op == flrw_pkg::OP_WRITE, req_id};
    end
    rd_q <= wait_mem_q[head_d];
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // waiter count stays below the queue depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH - 1))
    else $error("wait queue over capacity");

  // a held write lock has no reader holders
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == flrw_pkg::MODE_WRITE |-> holders_q == '0)
    else $error("readers counted under write lock");

  // between commands a free lock has nobody waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == flrw_pkg::ST_IDLE && mode_q == flrw_pkg::MODE_FREE) |-> q_empty)
    else $error("waiters left on a free lock");

  // between commands a read lock has at least one holder
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == flrw_pkg::ST_IDLE && mode_q == flrw_pkg::MODE_READ) |-> holders_q != '0)
    else $error("read lock with no holders");

  // a reader run only happens under a read lock
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == flrw_pkg::ST_WAKE_R |-> mode_q == flrw_pkg::MODE_READ)
    else $error("reader wake outside read mode");

endmodule

@@ hdl/fifo_reader_writer_lock_manager.sv @@
// Fair FIFO reader-writer lock manager, top level.
// An item passes the command queue, the back end's fetch and execute steps, then the
// output register. The back end takes a new command only once done with the last, and a
// result stall holds it; a reader wake adds a wake step and one result per woken reader.
// Reset clears the lock to free, empties the wait queue and drops any pending result;
// wait queue entries need no clearing since only entries written are read.
`timescale 1ns / 1ps
module fifo_reader_writer_lock_manager #(
  parameter int QUEUE_DEPTH    = flrw_pkg::QUEUE_DEPTH_DEF,
  parameter int REQUESTER_BITS = flrw_pkg::REQUESTER_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  flrw_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output flrw_pkg::out_item_t out_item_o
);

  logic           q_full;
  logic           q_push;
  flrw_pkg::cmd_t q_cmd_in;
  logic           q_valid;
  logic           q_pop;
  flrw_pkg::cmd_t q_cmd_out;

  // request decode
  flrw_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_cmd_in)
  );

  // decoupling queue
  flrw_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .cmd_o   (q_cmd_out)
  );

  // lock execution
  flrw_back #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .REQUESTER_BITS (REQUESTER_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd_out),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ tb/sv/flrw_lock_checker.sv @@
// result predictor and scoreboard for the reader-writer lock manager
`timescale 1ns / 1ps
module flrw_lock_checker
  import flrw_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        pending_o,
  output mode_e     mode_o,
  output logic [7:0] owner_o
);

  localparam int QDEPTH = QUEUE_DEPTH_DEF;

  // predicted lock state
  mode_e      lk_mode = MODE_FREE;
  logic [7:0] lk_owner = '0;
  int         rd_holders = 0;
  int         rd_before_wr = 0;
  logic [7:0] wq_id [QDEPTH];
  logic       wq_wr [QDEPTH];
  int         wq_head = 0;
  int         wq_count = 0;

  // results of the item being predicted, then all results still owed
  logic [7:0] step_who [$];
  ev_e        step_ev [$];
  out_item_t  owed_results [$];

  assign mode_o  = lk_mode;
  assign owner_o = lk_owner;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic note(logic [7:0] who, ev_e ev);
    step_who.push_back(who);
    step_ev.push_back(ev);
  endtask

  task automatic enqueue_waiter(logic [7:0] who, logic writer);
    int tail;
    tail = (wq_head + wq_count) % QDEPTH;
    wq_id[tail] = who;
    wq_wr[tail] = writer;
    wq_count++;
  endtask

  task automatic dequeue_waiter(output logic [7:0] who);
    who = wq_id[wq_head];
    wq_head = (wq_head + 1) % QDEPTH;
    wq_count--;
  endtask

  // lock has no holder: hand it to one writer or to the run of readers at the head
  task automatic wake_head();
    logic [7:0] who;
    int n;
    n = 0;
    rd_holders = 0;
    rd_before_wr = 0;
    lk_owner = '0;
    if (wq_count == 0) begin
      lk_mode = MODE_FREE;
    end else if (wq_wr[wq_head]) begin
      dequeue_waiter(who);
      lk_mode = MODE_WRITE;
      lk_owner = who;
      note(who, EV_WOKEN);
    end else begin
      while (wq_count != 0 && !wq_wr[wq_head]) begin
        dequeue_waiter(who);
        note(who, EV_WOKEN);
        n++;
      end
      lk_mode = MODE_READ;
      rd_holders = n;
      rd_before_wr = (wq_count != 0) ? n : 0;
    end
  endtask

  // work out the results of one accepted request
  task automatic predict_lock_request(in_item_t it);
    logic [7:0] r;
    logic       full;
    out_item_t  res;
    int         n;
    r = it.requester;
    full = (wq_count >= QDEPTH - 1);
    step_who.delete();
    step_ev.delete();
    case (it.action)
      ACT_READ: begin
        if (lk_mode != MODE_WRITE && wq_count == 0) begin
          if (rd_holders >= READER_MAX) begin
            note(r, EV_ERROR);
          end else begin
            rd_holders++;
            lk_mode = MODE_READ;
            note(r, EV_GRANTED);
          end
        end else if (full) begin
          note(r, EV_ERROR);
        end else begin
          enqueue_waiter(r, 1'b0);
          note(r, EV_QUEUED);
        end
      end
      ACT_WRITE: begin
        if (lk_mode == MODE_WRITE && lk_owner == r) begin
          note(r, EV_ERROR);
        end else if (lk_mode == MODE_FREE && wq_count == 0) begin
          lk_mode = MODE_WRITE;
          lk_owner = r;
          note(r, EV_GRANTED);
        end else if (full) begin
          note(r, EV_ERROR);
        end else begin
          if (lk_mode == MODE_READ && wq_count == 0) rd_before_wr = rd_holders;
          enqueue_waiter(r, 1'b1);
          note(r, EV_QUEUED);
        end
      end
      ACT_UNLOCK: begin
        if (lk_mode == MODE_WRITE) begin
          if (lk_owner != r) begin
            note(r, EV_ERROR);
          end else begin
            note(r, EV_RELEASED);
            wake_head();
          end
        end else if (lk_mode == MODE_READ) begin
          if (rd_holders > 0) rd_holders--;
          if (rd_before_wr > 0) rd_before_wr--;
          note(r, EV_RELEASED);
          if (rd_holders == 0) wake_head();
        end else begin
          note(r, EV_ERROR);
        end
      end
      default: begin
        note(r, EV_ERROR);
      end
    endcase
    // every result of the step carries the final mode
    n = step_who.size();
    for (int i = 0; i < n; i++) begin
      res.who        = step_who[i];
      res.event_res  = step_ev[i];
      res.mode_after = lk_mode;
      res.is_last    = (i == n - 1);
      owed_results.push_back(res);
    end
  endtask

  task automatic field_mismatch(string field, int want, int got);
    $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
    fail_count_o++;
  endtask

  // compare one result with the oldest one owed
  task automatic check_result(out_item_t got);
    out_item_t want;
    if (owed_results.size() == 0) begin
      $display("%0t: unexpected result who=%0h event=%0d mode=%0d last=%0b",
               $time, got.who, got.event_res, got.mode_after, got.is_last);
      fail_count_o++;
    end else begin
      want = owed_results.pop_front();
      if (got.who != want.who) field_mismatch("who", int'(want.who), int'(got.who));
      if (got.event_res != want.event_res)
        field_mismatch("event_res", int'(want.event_res), int'(got.event_res));
      if (got.mode_after != want.mode_after)
        field_mismatch("mode_after", int'(want.mode_after), int'(got.mode_after));
      if (got.is_last != want.is_last)
        field_mismatch("is_last", int'(want.is_last), int'(got.is_last));
    end
  endtask

  // results are checked before the item of the same edge is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lk_mode = MODE_FREE;
      lk_owner = '0;
      rd_holders = 0;
      rd_before_wr = 0;
      wq_head = 0;
      wq_count = 0;
      owed_results.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result(out_item_i);
      if (in_valid_i && !in_stall_i) predict_lock_request(in_item_i);
      pending_o = owed_results.size();
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// stimulus and verdict for the reader-writer lock manager testbench
`timescale 1ns / 1ps
module tb;
  import flrw_pkg::*;

  // action code the block must reject
  localparam logic [1:0] ACT_BAD = 2'd3;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;
  int         fail_count;
  int         pending;
  mode_e      lock_mode;
  logic [7:0] lock_owner;

  int idle_pct = 0;
  int stall_pct = 0;
  int sent_items = 0;

  fifo_reader_writer_lock_manager uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  flrw_lock_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .mode_o       (lock_mode),
    .owner_o      (lock_owner)
  );

  always #1 clk = ~clk;

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic logic [7:0] rand_id();
    return 8'($urandom_range(255));
  endfunction

  // offer one item after a random idle gap and hold it until taken
  task automatic send_item(logic [1:0] act, logic [7:0] id);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{action: act, requester: id};
    do @(posedge clk); while (in_stall);
    sent_items++;
    @(negedge clk);
  endtask

  // sender goes quiet until every owed result is back
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // unlock until the lock is free, using the owner while a writer holds it
  task automatic release_all();
    int k;
    k = 0;
    while (lock_mode != MODE_FREE && k < 600) begin
      send_item(ACT_UNLOCK, (lock_mode == MODE_WRITE) ? lock_owner : rand_id());
      k++;
    end
  endtask

  // take the lock, pile up waiters (at times to a full queue), then release everything
  task automatic run_waiter_burst();
    int n;
    release_all();
    send_item(($urandom_range(3) == 0) ? ACT_READ : ACT_WRITE, rand_id());
    n = $urandom_range(4, 17);
    repeat (n) send_item(($urandom_range(9) < 7) ? ACT_READ : ACT_WRITE, rand_id());
    release_all();
  endtask

  // unstructured requests, unlocks mostly by the current owner
  task automatic run_noise();
    int         pick;
    logic [1:0] act;
    logic [7:0] id;
    repeat ($urandom_range(1, 8)) begin
      pick = $urandom_range(99);
      if (pick < 38) act = ACT_READ;
      else if (pick < 62) act = ACT_WRITE;
      else if (pick < 97) act = ACT_UNLOCK;
      else act = ACT_BAD;
      id = rand_id();
      if ((act == ACT_UNLOCK && $urandom_range(3) != 0) ||
          (act == ACT_WRITE && $urandom_range(9) == 0)) id = lock_owner;
      send_item(act, id);
    end
  endtask

  initial begin
    #2000000;
    $display("fifo_reader_writer_lock_manager regression: fail");
    $finish;
  end

  initial begin
    int idle_by_phase [4];
    int stall_by_phase [4];
    int phase_end;
    idle_by_phase  = '{0, 73, 0, 11};
    stall_by_phase = '{0, 0, 73, 11};
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: errors, grants, queueing behind a writer, wake of writer and reader run
    send_item(ACT_UNLOCK, 8'h00);   // unlock of a free lock
    send_item(ACT_BAD, 8'hFF);
    send_item(ACT_WRITE, 8'hFF);
    send_item(ACT_UNLOCK, 8'hFF);
    send_item(ACT_READ, 8'h00);
    send_item(ACT_READ, 8'hFF);
    send_item(ACT_WRITE, 8'h5A);    // waits on two readers
    send_item(ACT_READ, 8'h11);     // waits behind the writer
    send_item(ACT_UNLOCK, 8'h33);   // reader unlock by any id
    send_item(ACT_UNLOCK, 8'h00);   // last reader out wakes the writer
    send_item(ACT_WRITE, 8'h5A);    // nested write lock
    send_item(ACT_UNLOCK, 8'hA5);   // unlock by non-owner
    send_item(ACT_READ, 8'h22);
    send_item(ACT_WRITE, 8'h44);
    send_item(ACT_READ, 8'h66);
    send_item(ACT_UNLOCK, 8'h5A);   // wakes readers up to the waiting writer
    send_item(ACT_UNLOCK, 8'h11);
    send_item(ACT_UNLOCK, 8'h22);
    send_item(ACT_UNLOCK, 8'h44);
    send_item(ACT_UNLOCK, 8'h66);
    hold_until_drained();

    // random phases with different idle and stall mixes
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_by_phase[p];
      stall_pct = stall_by_phase[p];
      phase_end = sent_items + 50;
      while (sent_items < phase_end) begin
        if ($urandom_range(9) < 6) begin
          run_waiter_burst();
        end else begin
          run_noise();
        end
      end
      release_all();
      hold_until_drained();
    end

    hold_until_drained();
    repeat (16) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("fifo_reader_writer_lock_manager regression: pass");
    end else begin
      $display("fifo_reader_writer_lock_manager regression: fail");
    end
    $finish;
  end

endmodule
